FILE: rtl/gpse_pkg.sv
// Package: shared types and codes for the postfix stack evaluator.
`default_nettype none
package gpse_pkg;
    typedef logic [3:0] t_op;
    localparam t_op OP_X    = 4'd0;
    localparam t_op OP_Y    = 4'd1;
    localparam t_op OP_SUM  = 4'd2;
    localparam t_op OP_RAND = 4'd3;
    localparam t_op OP_ZERO = 4'd4;
    localparam t_op OP_ADD  = 4'd5;
    localparam t_op OP_SUB  = 4'd6;
    localparam t_op OP_MUL  = 4'd7;
    localparam t_op OP_DIV  = 4'd8;
    localparam t_op OP_KEEPA = 4'd9;
    localparam t_op OP_KEEPB = 4'd10;
    localparam t_op OP_DROP = 4'd11;

    typedef logic [1:0] t_err;
    localparam t_err ERR_OK    = 2'd0;
    localparam t_err ERR_UNDER = 2'd1;
    localparam t_err ERR_OVER  = 2'd2;
    localparam t_err ERR_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_A, ST_RD_B, ST_WAIT, ST_ALU, ST_ALU_WAIT, ST_PUSH, ST_RD_TOP,
        ST_TOP_WAIT, ST_OUT
    } t_state;

    // request to the arithmetic unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_alu_req;
endpackage
`default_nettype wire

FILE: rtl/gpse_alu.sv
// Shared iterative arithmetic unit: saturating add/sub, shift-add mul, restoring div.
`default_nettype none
module gpse_alu #(
    parameter int FRAC_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire gpse_pkg::t_alu_req i_req,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic o_done,
    output logic [63:0] o_res
);
    localparam logic [63:0] MaxPos = {1'b0, {63{1'b1}}};
    localparam logic [63:0] MinNeg = {1'b1, 63'd0};

    logic        r_busy, n_busy;
    logic        r_div, n_div;
    logic [7:0]  r_cnt, n_cnt;
    logic        r_neg, n_neg;
    logic [127:0] r_acc, n_acc;   // mul product or div quotient/numerator shifter
    logic [63:0] r_mb, n_mb;      // multiplicand or divisor magnitude
    logic [64:0] r_rem, n_rem;
    logic        r_done, n_done;
    logic [63:0] r_res, n_res;

    logic [63:0] w_ma, w_mb, w_sum, w_dif;
    logic [64:0] w_remsh;
    logic [127:0] w_sh;
    logic        w_hi_nz;
    logic [63:0] w_lo;

    always_comb begin
        w_ma  = i_a[63] ? (64'd0 - i_a) : i_a;
        w_mb  = i_b[63] ? (64'd0 - i_b) : i_b;
        w_sum = i_a + i_b;
        w_dif = i_a - i_b;
        w_remsh = {r_rem[63:0], r_acc[127]};
        w_sh  = r_div ? r_acc : (r_acc >> FRAC_BITS);
        w_hi_nz = |w_sh[127:64];
        w_lo  = w_sh[63:0];
    end

    always_comb begin
        n_busy = r_busy; n_div = r_div; n_cnt = r_cnt; n_neg = r_neg;
        n_acc = r_acc; n_mb = r_mb; n_rem = r_rem; n_done = 1'b0; n_res = r_res;
        if (i_req.start) begin
            case (i_req.op)
                gpse_pkg::OP_ADD: begin
                    n_done = 1'b1;
                    n_res = (~(i_a[63] ^ i_b[63]) & (w_sum[63] ^ i_a[63]))
                        ? (i_a[63] ? MinNeg : MaxPos) : w_sum;
                end
                gpse_pkg::OP_SUB: begin
                    n_done = 1'b1;
                    n_res = ((i_a[63] ^ i_b[63]) & (w_dif[63] ^ i_a[63]))
                        ? (i_a[63] ? MinNeg : MaxPos) : w_dif;
                end
                gpse_pkg::OP_MUL: begin
                    n_busy = 1'b1; n_div = 1'b0; n_cnt = 8'd64;
                    n_neg = i_a[63] ^ i_b[63];
                    n_acc = {64'd0, w_mb};      // multiplier in low half
                    n_mb = w_ma;
                end
                gpse_pkg::OP_DIV: begin
                    if (i_b == 64'd0) begin
                        n_done = 1'b1; n_res = i_a;
                    end else begin
                        n_busy = 1'b1; n_div = 1'b1; n_cnt = 8'd128;
                        n_neg = i_a[63] ^ i_b[63];
                        n_acc = {64'd0, w_ma} << FRAC_BITS;
                        n_mb = w_mb; n_rem = 65'd0;
                    end
                end
                default: begin
                    n_done = 1'b1; n_res = i_a;
                end
            endcase
        end else if (r_busy) begin
            if (r_cnt != 8'd0) begin
                n_cnt = r_cnt - 8'd1;
                if (r_div) begin
                    if (w_remsh >= {1'b0, r_mb}) begin
                        n_rem = w_remsh - {1'b0, r_mb};
                        n_acc = {r_acc[126:0], 1'b1};
                    end else begin
                        n_rem = w_remsh;
                        n_acc = {r_acc[126:0], 1'b0};
                    end
                end else begin
                    // shift-add: high half accumulates, shift right
                    n_acc = {({1'b0, r_acc[127:64]} + (r_acc[0] ? {1'b0, r_mb} : 65'd0)),
                             r_acc[63:1]};
                end
            end else begin
                n_busy = 1'b0; n_done = 1'b1;
                if (r_neg) n_res = (w_hi_nz || w_lo > MinNeg) ? MinNeg : (64'd0 - w_lo);
                else n_res = (w_hi_nz || w_lo >= MinNeg) ? MaxPos : w_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_div <= n_div; r_cnt <= n_cnt; r_neg <= n_neg; r_acc <= n_acc;
        r_mb <= n_mb; r_rem <= n_rem; r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == 8'd0 && !i_req.start |=> o_done) else $error("alu done missing");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("alu restarted while busy");
    a_busy_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_busy) && r_busy |-> !o_done) else $error("alu done while busy");
endmodule
`default_nettype wire

FILE: rtl/gp_postfix_stack_evaluator.sv
// Top level: postfix token evaluator with operand stack and shared arithmetic unit.
// Loads stay in idle; pushes, drops and operators step through the stack read, arithmetic
// and push states as they need them. Mul and div run longest, set by the
// one-bit-per-cycle shift-add (64 steps) and restoring divide (128 steps) in the shared
// unit. A last token adds the top read and output states plus any output stall.
// Throughput: one transaction at a time; s_axis_tready is high only when idle.
// Reset (synchronous, active low) clears stack count, terminals, error and rand register.
`default_nettype none
module gp_postfix_stack_evaluator #(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_we,
    input  wire logic [63:0] i_cfg_wdata,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // tdata: x_value[63:0], y_value[127:64], sum_value[191:128], op_code[195:192], zero pad
    input  wire logic [199:0] s_axis_tdata,
    // tuser: mode
    input  wire logic s_axis_tuser,
    input  wire logic s_axis_tlast,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // tdata: result_value[63:0], error_code[65:64], zero pad
    output logic [71:0] m_axis_tdata
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] Full = CW'(STACK_DEPTH);

    gpse_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    gpse_pkg::t_err r_err, n_err;
    logic [63:0] r_x, r_y, r_sum, r_rand;
    gpse_pkg::t_op r_op, n_op;
    logic r_last, n_last;
    logic [63:0] r_a, n_a, r_b, n_b, r_pv, n_pv;
    logic r_ovalid, n_ovalid;
    logic [63:0] r_ores, n_ores;
    gpse_pkg::t_err r_oerr, n_oerr;

    // stack memory, one read port registered
    logic [63:0] r_mem [STACK_DEPTH];
    logic [63:0] r_rd;
    logic w_we;
    logic [AW-1:0] w_wa, w_ra;

    gpse_pkg::t_alu_req w_req;
    logic w_done;
    logic [63:0] w_res;

    gpse_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .i_a(r_a), .i_b(r_b),
        .o_done(w_done), .o_res(w_res));

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= r_pv;
        r_rd <= r_mem[w_ra];
    end

    logic w_acc;
    gpse_pkg::t_op w_op;
    assign w_op = s_axis_tdata[195:192];
    assign s_axis_tready = (r_state == gpse_pkg::ST_IDLE) && !r_ovalid;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_err = r_err; n_op = r_op; n_last = r_last;
        n_a = r_a; n_b = r_b; n_pv = r_pv; n_ovalid = r_ovalid; n_ores = r_ores;
        n_oerr = r_oerr;
        w_we = 1'b0; w_wa = r_cnt[AW-1:0]; w_ra = r_cnt[AW-1:0] - AW'(1);
        w_req = '0;
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;
        case (r_state)
            gpse_pkg::ST_IDLE: begin
                if (w_acc && s_axis_tuser) begin
                    n_op = w_op; n_last = s_axis_tlast;
                    case (w_op)
                        gpse_pkg::OP_X: n_pv = r_x;
                        gpse_pkg::OP_Y: n_pv = r_y;
                        gpse_pkg::OP_SUM: n_pv = r_sum;
                        gpse_pkg::OP_RAND: n_pv = r_rand;
                        default: n_pv = 64'd0;
                    endcase
                    if (w_op <= gpse_pkg::OP_ZERO) n_state = gpse_pkg::ST_PUSH;
                    else if (w_op <= gpse_pkg::OP_DROP) begin
                        if (r_cnt < CW'(2)) begin
                            if (r_err == gpse_pkg::ERR_OK) n_err = gpse_pkg::ERR_UNDER;
                            n_state = s_axis_tlast ? gpse_pkg::ST_RD_TOP : gpse_pkg::ST_IDLE;
                        end else n_state = gpse_pkg::ST_RD_A;
                    end else n_state = s_axis_tlast ? gpse_pkg::ST_RD_TOP : gpse_pkg::ST_IDLE;
                end
            end
            gpse_pkg::ST_RD_A: begin
                w_ra = r_cnt[AW-1:0] - AW'(1);
                n_state = gpse_pkg::ST_RD_B;
            end
            gpse_pkg::ST_RD_B: begin
                w_ra = r_cnt[AW-1:0] - AW'(2);
                n_a = r_rd;
                n_state = gpse_pkg::ST_WAIT;
            end
            gpse_pkg::ST_WAIT: begin
                n_b = r_rd;
                n_cnt = r_cnt - CW'(2);
                n_state = (r_op == gpse_pkg::OP_DROP)
                    ? (r_last ? gpse_pkg::ST_RD_TOP : gpse_pkg::ST_IDLE) : gpse_pkg::ST_ALU;
            end
            gpse_pkg::ST_ALU: begin
                w_req.start = 1'b1;
                w_req.op = r_op;
                // keep b: feed b as a through the unit's pass path
                if (r_op == gpse_pkg::OP_KEEPB) n_a = r_b;
                n_state = (r_op == gpse_pkg::OP_KEEPB) ? gpse_pkg::ST_ALU : gpse_pkg::ST_ALU_WAIT;
                if (r_op == gpse_pkg::OP_KEEPB) n_op = gpse_pkg::OP_KEEPA;
                if (r_op == gpse_pkg::OP_KEEPB) w_req.start = 1'b0;
            end
            gpse_pkg::ST_ALU_WAIT: begin
                if (w_done) begin
                    n_pv = w_res;
                    n_state = gpse_pkg::ST_PUSH;
                end
            end
            gpse_pkg::ST_PUSH: begin
                if (r_cnt >= Full) begin
                    if (r_err == gpse_pkg::ERR_OK) n_err = gpse_pkg::ERR_OVER;
                end else begin
                    w_we = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end
                n_state = r_last ? gpse_pkg::ST_RD_TOP : gpse_pkg::ST_IDLE;
            end
            gpse_pkg::ST_RD_TOP: begin
                w_ra = r_cnt[AW-1:0] - AW'(1);
                n_state = gpse_pkg::ST_TOP_WAIT;
            end
            gpse_pkg::ST_TOP_WAIT: begin
                n_state = gpse_pkg::ST_OUT;
            end
            gpse_pkg::ST_OUT: begin
                if (!r_ovalid) begin
                    n_ovalid = 1'b1;
                    n_ores = (r_cnt != '0) ? r_rd : 64'd0;
                    n_oerr = (r_err == gpse_pkg::ERR_OK && r_cnt == '0)
                        ? gpse_pkg::ERR_EMPTY : r_err;
                    n_cnt = '0; n_err = gpse_pkg::ERR_OK;
                    n_state = gpse_pkg::ST_IDLE;
                end
            end
            default: n_state = gpse_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gpse_pkg::ST_IDLE; r_cnt <= '0; r_err <= gpse_pkg::ERR_OK;
            r_x <= '0; r_y <= '0; r_sum <= '0; r_rand <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_err <= n_err; r_ovalid <= n_ovalid;
            if (i_cfg_we) r_rand <= i_cfg_wdata;
            if (w_acc && !s_axis_tuser) begin
                r_x <= s_axis_tdata[63:0];
                r_y <= s_axis_tdata[127:64];
                r_sum <= s_axis_tdata[191:128];
            end
        end
        r_op <= n_op; r_last <= n_last; r_a <= n_a; r_b <= n_b; r_pv <= n_pv;
        r_ores <= n_ores; r_oerr <= n_oerr;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {6'd0, r_oerr, r_ores};

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Full) else $error("stack count beyond depth");
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != gpse_pkg::ST_IDLE |-> !s_axis_tready) else $error("ready while busy");
    a_out_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gpse_pkg::ST_OUT && !r_ovalid |=> r_cnt == '0 && r_err == gpse_pkg::ERR_OK)
        else $error("stack not cleared after result");
endmodule
`default_nettype wire
